@@ design/bwpt_pkg.sv @@
// ----------------------------------------------------------------------------
// bwpt_pkg
// Shared types and constants of the baseline wavelet pulse trigger.
// ----------------------------------------------------------------------------
package bwpt_pkg;

    localparam int RING_DEPTH = 128;
    localparam int RING_AW    = 7;
    localparam int MAX_TRACE  = 131072;

    localparam logic [2:0] REG_MAIN_THR  = 3'd0;
    localparam logic [2:0] REG_MINOR_THR = 3'd1;
    localparam logic [2:0] REG_QUIET_BEF = 3'd2;
    localparam logic [2:0] REG_QUIET_AFT = 3'd3;
    localparam logic [2:0] REG_RULES     = 3'd4;
    localparam logic [2:0] REG_BL_LIMIT  = 3'd5;
    localparam logic [2:0] REG_BL_LOG2   = 3'd6;
    localparam logic [2:0] REG_EXP_POS   = 3'd7;

    localparam logic [2:0] VERD_WAIT  = 3'd0;
    localparam logic [2:0] VERD_ARMED = 3'd1;
    localparam logic [2:0] VERD_TRIG  = 3'd2;
    localparam logic [2:0] VERD_GAP   = 3'd3;
    localparam logic [2:0] VERD_COUNT = 3'd4;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               first;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] corrected_sample;
        logic [14:0]        wavelet_value;
        logic [2:0]         verdict;
        logic [16:0]        trigger_position;
        logic               trigger_now;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] corr;
        logic               first;
    } mid_item_t;

    typedef struct packed {
        logic [11:0] main_threshold;
        logic [11:0] minor_threshold;
        logic [8:0]  quiet_before;
        logic [8:0]  quiet_after;
        logic [11:0] minor_rules;
        logic [9:0]  baseline_limit;
        logic [2:0]  baseline_log2;
        logic [15:0] expected_position;
    } cfg_t;

endpackage

@@ design/bwpt_front.sv @@
// ----------------------------------------------------------------------------
// bwpt_front
// Baseline ring and running sum; subtracts the baseline average per item.
// ----------------------------------------------------------------------------
module bwpt_front
    import bwpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      q_valid,
    input  logic      q_ready,
    output mid_item_t q_item
);

    logic signed [15:0] mem [0:RING_DEPTH-1];
    logic [RING_DEPTH-1:0] ring_vld_reg;
    logic [RING_AW-1:0]    ptr_reg;
    logic signed [23:0]    sum_reg;

    logic                  stg_valid_reg;
    logic signed [15:0]    stg_sample_reg;
    logic                  stg_first_reg;
    logic                  stg_in_ring_reg;
    logic [RING_AW-1:0]    stg_addr_reg;
    logic signed [15:0]    rd_data_reg;
    logic                  fwd_reg;
    logic signed [15:0]    fwd_data_reg;
    logic                  hit_reg;

    logic                  accept;
    logic                  stg_fire;
    logic [7:0]            len;
    logic [RING_AW-1:0]    ptr_eff;
    logic [RING_AW-1:0]    addr_in;
    logic [7:0]            ptr_inc;
    logic [RING_AW-1:0]    ptr_next;
    logic signed [16:0]    s17;
    logic signed [16:0]    lim17;
    logic                  in_ring;
    logic                  fwd_hit;

    logic signed [23:0]    sum_eff;
    logic signed [23:0]    sum_next;
    logic signed [15:0]    old_val;
    logic signed [23:0]    bias;
    logic signed [23:0]    avg;

    assign len      = 8'd1 << cfg.baseline_log2;
    assign stg_fire = stg_valid_reg && q_ready;
    assign in_ready = !stg_valid_reg || stg_fire;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ptr_eff = in_item.first ? '0 : ptr_reg;
        if ({1'b0, ptr_eff} >= len)
        begin
            addr_in = '0;
        end
        else
        begin
            addr_in = ptr_eff;
        end
        ptr_inc = {1'b0, addr_in} + 8'd1;
        s17     = 17'(in_item.sample);
        lim17   = signed'({7'b0, cfg.baseline_limit});
        in_ring = (s17 <= lim17) && (s17 >= -lim17);
        if (!in_ring)
        begin
            ptr_next = ptr_eff;
        end
        else if (ptr_inc >= len)
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = ptr_inc[RING_AW-1:0];
        end
        fwd_hit = stg_fire && stg_in_ring_reg && (stg_addr_reg == addr_in)
                  && !in_item.first;
    end

    always_comb
    begin
        sum_eff = stg_first_reg ? '0 : sum_reg;
        if (fwd_reg)
        begin
            old_val = fwd_data_reg;
        end
        else if (hit_reg)
        begin
            old_val = rd_data_reg;
        end
        else
        begin
            old_val = '0;
        end
        sum_next = stg_in_ring_reg ? (sum_eff - 24'(old_val) + 24'(stg_sample_reg))
                                   : sum_eff;
        bias = (sum_eff < 0) ? signed'({16'b0, len - 8'd1}) : '0;
        avg  = (sum_eff + bias) >>> cfg.baseline_log2;
    end

    assign q_valid      = stg_valid_reg;
    assign q_item.corr  = stg_sample_reg - avg[15:0];
    assign q_item.first = stg_first_reg;

    // ring storage and registered read
    always_ff @(posedge clk)
    begin
        if (stg_fire && stg_in_ring_reg)
        begin
            mem[stg_addr_reg] <= stg_sample_reg;
        end
        if (accept)
        begin
            rd_data_reg    <= mem[addr_in];
            fwd_data_reg   <= stg_sample_reg;
            stg_sample_reg <= in_item.sample;
            stg_first_reg  <= in_item.first;
            stg_in_ring_reg <= in_ring;
            stg_addr_reg   <= addr_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            ring_vld_reg  <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            fwd_reg       <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stg_valid_reg <= 1'b1;
                ptr_reg       <= ptr_next;
                fwd_reg       <= fwd_hit;
                hit_reg       <= ring_vld_reg[addr_in] && !in_item.first;
            end
            else if (stg_fire)
            begin
                stg_valid_reg <= 1'b0;
            end
            if (stg_fire)
            begin
                sum_reg <= sum_next;
            end
            if (accept && in_item.first)
            begin
                ring_vld_reg <= '0;
            end
            else if (stg_fire && stg_in_ring_reg)
            begin
                ring_vld_reg[stg_addr_reg] <= 1'b1;
            end
        end
    end

endmodule

@@ design/bwpt_queue.sv @@
// ----------------------------------------------------------------------------
// bwpt_queue
// Two-entry queue between the baseline front and the trigger back end.
// ----------------------------------------------------------------------------
module bwpt_queue
    import bwpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  mid_item_t wr_item,
    output logic      rd_valid,
    input  logic      rd_ready,
    output mid_item_t rd_item
);

    mid_item_t  slot_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");

    a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count did not follow push");

    a_empty_no_pop : assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");

endmodule

@@ design/bwpt_back.sv @@
// ----------------------------------------------------------------------------
// bwpt_back
// Wavelet, T1/T2 trigger search and the result register.
// ----------------------------------------------------------------------------
module bwpt_back
    import bwpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    output logic      q_ready,
    input  mid_item_t q_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic signed [15:0] pc_reg,    pc_next;
    logic [17:0]        idx_reg,   idx_next;
    logic signed [2:0]  off_reg,   off_next;
    logic               armed_reg, armed_next;
    logic               lmain_vld_reg, lmain_vld_next;
    logic [17:0]        lmain_reg, lmain_next;
    logic [10:0]        pl_reg,    pl_next;
    logic [16:0]        mc_reg,    mc_next;
    logic               lmin_vld_reg, lmin_vld_next;
    logic [17:0]        lmin_reg,  lmin_next;
    logic [2:0]         verd_reg,  verd_next;
    logic [16:0]        found_reg, found_next;

    logic               out_valid_reg;
    out_item_t          out_reg, out_next;
    logic               pop;

    logic signed [15:0] pc_e;
    logic [17:0]        idx_e;
    logic signed [2:0]  off_e;
    logic               armed_e;
    logic               lmain_vld_e;
    logic [17:0]        lmain_e;
    logic [10:0]        pl_e;
    logic [16:0]        mc_e;
    logic               lmin_vld_e;
    logic [17:0]        lmin_e;
    logic [2:0]         verd_e;
    logic [16:0]        found_e;

    logic signed [16:0] diff;
    logic signed [16:0] half;
    logic [16:0]        mag;
    logic [14:0]        w;
    logic signed [19:0] i20;
    logic signed [19:0] et1;
    logic signed [19:0] gap;
    logic signed [19:0] pre;
    logic [10:0]        post;
    logic signed [16:0] t1;
    logic signed [16:0] t2;
    logic signed [16:0] w17;
    logic [16:0]        mc_inc;
    logic [2:0]         vout;

    assign q_ready   = !out_valid_reg || out_ready;
    assign pop       = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        // trace restart clears the working state
        if (q_item.first)
        begin
            pc_e = '0; idx_e = '0; off_e = '0; armed_e = 1'b0;
            lmain_vld_e = 1'b0; lmain_e = '0; pl_e = '0; mc_e = '0;
            lmin_vld_e = 1'b0; lmin_e = '0; verd_e = VERD_WAIT; found_e = '0;
        end
        else
        begin
            pc_e = pc_reg; idx_e = idx_reg; off_e = off_reg; armed_e = armed_reg;
            lmain_vld_e = lmain_vld_reg; lmain_e = lmain_reg; pl_e = pl_reg;
            mc_e = mc_reg; lmin_vld_e = lmin_vld_reg; lmin_e = lmin_reg;
            verd_e = verd_reg; found_e = found_reg;
        end

        diff = 17'(pc_e) - 17'(q_item.corr);
        half = diff >>> 1;
        mag  = (half < 0) ? 17'(-half) : 17'(half);
        if (idx_e == '0)
        begin
            w = '0;
        end
        else if (mag > 17'd32767)
        begin
            w = 15'h7fff;
        end
        else
        begin
            w = mag[14:0];
        end

        i20  = signed'({2'b0, idx_e});
        et1  = signed'({4'b0, cfg.expected_position})
               - signed'({10'b0, cfg.quiet_after, 1'b0});
        gap  = signed'({16'b0, cfg.minor_rules[11:9], 1'b0});
        pre  = signed'({10'b0, cfg.quiet_before, 1'b0});
        post = {1'b0, cfg.quiet_after, 1'b0};
        w17  = signed'({2'b0, w});
        t2   = signed'({5'b0, cfg.minor_threshold}) + 17'sd2;

        pc_next = q_item.corr;
        idx_next = idx_e; off_next = off_e; armed_next = armed_e;
        lmain_vld_next = lmain_vld_e; lmain_next = lmain_e; pl_next = pl_e;
        mc_next = mc_e; lmin_vld_next = lmin_vld_e; lmin_next = lmin_e;
        verd_next = verd_e; found_next = found_e;
        mc_inc = mc_e;
        t1 = '0;

        if (!idx_e[17])
        begin
            idx_next = idx_e + 18'd1;
            if (verd_e != VERD_TRIG)
            begin
                if (i20 == et1 - 20'sd10)
                begin
                    off_next = (off_e < -3'sd1) ? -3'sd4 : off_e - 3'sd3;
                end
                if (i20 == et1 + 20'sd10)
                begin
                    off_next = (off_next > 3'sd0) ? 3'sd3 : off_next + 3'sd3;
                end
                t1 = signed'({5'b0, cfg.main_threshold}) + 17'sd2 + 17'(off_next);

                if (armed_e)
                begin
                    if (pl_e != 11'h7ff)
                    begin
                        pl_next = pl_e + 11'd1;
                    end
                    if (w17 > t2)
                    begin
                        if (lmin_vld_e && (lmin_e != '0)
                            && ((i20 - signed'({2'b0, lmin_e})) > gap))
                        begin
                            verd_next = VERD_GAP;
                        end
                        lmin_vld_next = 1'b1;
                        lmin_next     = idx_e;
                        if (mc_e != 17'h1ffff)
                        begin
                            mc_inc = mc_e + 17'd1;
                        end
                        mc_next = mc_inc;
                        if ((mc_inc > 17'(cfg.minor_rules[4:0]))
                            || (mc_inc < 17'(cfg.minor_rules[8:5])))
                        begin
                            verd_next = VERD_COUNT;
                        end
                    end
                    if (pl_next == post)
                    begin
                        armed_next = 1'b0;
                        if (verd_next == VERD_WAIT)
                        begin
                            verd_next  = VERD_TRIG;
                            found_next = idx_e[16:0];
                        end
                    end
                end
                if (w17 >= t1)
                begin
                    if (!lmain_vld_e || ((i20 - signed'({2'b0, lmain_e})) > pre))
                    begin
                        armed_next = 1'b1;
                        pl_next    = '0;
                        verd_next  = VERD_WAIT;
                    end
                    lmain_vld_next = 1'b1;
                    lmain_next     = idx_e;
                    mc_next        = '0;
                    lmin_vld_next  = 1'b0;
                    lmin_next      = '0;
                end
            end
        end

        vout = ((verd_next == VERD_WAIT) && armed_next) ? VERD_ARMED : verd_next;
        out_next.corrected_sample = q_item.corr;
        out_next.wavelet_value    = w;
        out_next.verdict          = vout;
        out_next.trigger_position = (verd_next == VERD_TRIG) ? found_next : '0;
        out_next.trigger_now      = (verd_next == VERD_TRIG) && (verd_e != VERD_TRIG);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pc_reg <= '0; idx_reg <= '0; off_reg <= '0; armed_reg <= 1'b0;
            lmain_vld_reg <= 1'b0; lmain_reg <= '0; pl_reg <= '0; mc_reg <= '0;
            lmin_vld_reg <= 1'b0; lmin_reg <= '0; verd_reg <= VERD_WAIT;
            found_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                pc_reg <= pc_next; idx_reg <= idx_next; off_reg <= off_next;
                armed_reg <= armed_next; lmain_vld_reg <= lmain_vld_next;
                lmain_reg <= lmain_next; pl_reg <= pl_next; mc_reg <= mc_next;
                lmin_vld_reg <= lmin_vld_next; lmin_reg <= lmin_next;
                verd_reg <= verd_next; found_reg <= found_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ design/baseline_wavelet_pulse_trigger.sv @@
// ----------------------------------------------------------------------------
// baseline_wavelet_pulse_trigger
// Baseline-corrected wavelet pulse trigger with register port.
// ----------------------------------------------------------------------------
// result path: an accepted item is registered in the front stage, then the two-entry queue, then the result register
// throughput: one item per cycle when the result receiver does not stall
// baseline ring clears at once on a trace start through per-entry valid bits
// reset restores the control and configuration registers to their defaults and starts a fresh trace
module baseline_wavelet_pulse_trigger
    import bwpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  in_item_t    sample_item,
    output logic        result_valid,
    input  logic        result_ready,
    output out_item_t   result_item
);

    cfg_t      cfg_reg;
    logic      wr_en;
    logic      mid_valid, mid_ready;
    mid_item_t mid_item;
    logic      bk_valid, bk_ready;
    mid_item_t bk_item;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.main_threshold    <= 12'd100;
            cfg_reg.minor_threshold   <= 12'd50;
            cfg_reg.quiet_before      <= '0;
            cfg_reg.quiet_after       <= '0;
            cfg_reg.minor_rules       <= 12'd31;
            cfg_reg.baseline_limit    <= 10'd1023;
            cfg_reg.baseline_log2     <= '0;
            cfg_reg.expected_position <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_MAIN_THR:  cfg_reg.main_threshold    <= pwdata[11:0];
                REG_MINOR_THR: cfg_reg.minor_threshold   <= pwdata[11:0];
                REG_QUIET_BEF: cfg_reg.quiet_before      <= pwdata[8:0];
                REG_QUIET_AFT: cfg_reg.quiet_after       <= pwdata[8:0];
                REG_RULES:     cfg_reg.minor_rules       <= pwdata[11:0];
                REG_BL_LIMIT:  cfg_reg.baseline_limit    <= pwdata[9:0];
                REG_BL_LOG2:   cfg_reg.baseline_log2     <= pwdata[2:0];
                REG_EXP_POS:   cfg_reg.expected_position <= pwdata[15:0];
                default:       cfg_reg.main_threshold    <= cfg_reg.main_threshold;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_MAIN_THR:  prdata = {20'b0, cfg_reg.main_threshold};
            REG_MINOR_THR: prdata = {20'b0, cfg_reg.minor_threshold};
            REG_QUIET_BEF: prdata = {23'b0, cfg_reg.quiet_before};
            REG_QUIET_AFT: prdata = {23'b0, cfg_reg.quiet_after};
            REG_RULES:     prdata = {20'b0, cfg_reg.minor_rules};
            REG_BL_LIMIT:  prdata = {22'b0, cfg_reg.baseline_limit};
            REG_BL_LOG2:   prdata = {29'b0, cfg_reg.baseline_log2};
            REG_EXP_POS:   prdata = {16'b0, cfg_reg.expected_position};
            default:       prdata = '0;
        endcase
    end

    bwpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (sample_valid),
        .in_ready (sample_ready),
        .in_item  (sample_item),
        .q_valid  (mid_valid),
        .q_ready  (mid_ready),
        .q_item   (mid_item)
    );

    bwpt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (mid_valid),
        .wr_ready (mid_ready),
        .wr_item  (mid_item),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_item  (bk_item)
    );

    bwpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (bk_valid),
        .q_ready   (bk_ready),
        .q_item    (bk_item),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_item  (result_item)
    );

    a_now_is_trig : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.trigger_now) |-> (result_item.verdict == VERD_TRIG))
        else $error("trigger pulse without triggered verdict");

    a_pos_only_trig : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_item.verdict != VERD_TRIG))
        |-> (result_item.trigger_position == '0))
        else $error("trigger position set without trigger");

    a_cfg_write : assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (paddr[4:2] == REG_BL_LOG2)) |=> (cfg_reg.baseline_log2 == $past(pwdata[2:0])))
        else $error("ring length register not written");

endmodule

@@ tb/bwpt_scoreboard.sv @@
// ----------------------------------------------------------------------------
// bwpt_scoreboard
// Predicts each result of the pulse trigger from the accepted samples and
// checks the results that come out, in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import bwpt_pkg::*;

class bwpt_scoreboard;
    cfg_t            cfg;
    logic signed [15:0] ring [RING_DEPTH];
    int              ring_sum;
    int              ring_ptr;
    int              prev_corr;
    int              idx;
    int              offset;
    bit              armed;
    int              last_main;
    int              pulse_len;
    int              minor_cnt;
    int              last_minor;
    logic [2:0]      verdict_q;
    int              found_pos;
    out_item_t       pending [$];
    int              errors;

    function void set_defaults();
        cfg.main_threshold    = 12'd100;
        cfg.minor_threshold   = 12'd50;
        cfg.quiet_before      = 9'd0;
        cfg.quiet_after       = 9'd0;
        cfg.minor_rules       = 12'd31;
        cfg.baseline_limit    = 10'd1023;
        cfg.baseline_log2     = 3'd0;
        cfg.expected_position = 16'd0;
        clear_trace();
        errors = 0;
    endfunction

    function void clear_trace();
        foreach (ring[k]) ring[k] = '0;
        ring_sum = 0;
        ring_ptr = 0;
        prev_corr = 0;
        idx = 0;
        offset = 0;
        armed = 0;
        last_main = -1;
        pulse_len = 0;
        minor_cnt = 0;
        last_minor = -1;
        verdict_q = VERD_WAIT;
        found_pos = 0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] value);
        case (addr)
            REG_MAIN_THR:  cfg.main_threshold    = value[11:0];
            REG_MINOR_THR: cfg.minor_threshold   = value[11:0];
            REG_QUIET_BEF: cfg.quiet_before      = value[8:0];
            REG_QUIET_AFT: cfg.quiet_after       = value[8:0];
            REG_RULES:     cfg.minor_rules       = value[11:0];
            REG_BL_LIMIT:  cfg.baseline_limit    = value[9:0];
            REG_BL_LOG2:   cfg.baseline_log2     = value[2:0];
            default:       cfg.expected_position = value[15:0];
        endcase
    endfunction

    function void search(int i, int w);
        int exp_t1;
        int post;
        int pre;
        int gap;
        int cmin;
        int cmax;
        int t1;
        int t2;
        exp_t1 = int'(cfg.expected_position) - 2 * int'(cfg.quiet_after);
        post = 2 * int'(cfg.quiet_after);
        pre = 2 * int'(cfg.quiet_before);
        gap = 2 * int'(cfg.minor_rules[11:9]);
        cmin = int'(cfg.minor_rules[8:5]);
        cmax = int'(cfg.minor_rules[4:0]);
        if (i == exp_t1 - 10)
        begin
            offset -= 3;
            if (offset < -4) offset = -4;
        end
        if (i == exp_t1 + 10)
        begin
            offset += 3;
            if (offset > 3) offset = 3;
        end
        t1 = int'(cfg.main_threshold) + 2 + offset;
        t2 = int'(cfg.minor_threshold) + 2;
        if (armed)
        begin
            if (pulse_len < 'h7ff) pulse_len++;
            if (w > t2)
            begin
                if (last_minor > 0 && (i - last_minor) > gap) verdict_q = VERD_GAP;
                last_minor = i;
                if (minor_cnt < 'h1ffff) minor_cnt++;
                if (minor_cnt > cmax || minor_cnt < cmin) verdict_q = VERD_COUNT;
            end
            if (pulse_len == post)
            begin
                armed = 0;
                if (verdict_q == VERD_WAIT)
                begin
                    verdict_q = VERD_TRIG;
                    found_pos = i;
                end
            end
        end
        if (w >= t1)
        begin
            if (last_main < 0 || (i - last_main) > pre)
            begin
                armed = 1;
                pulse_len = 0;
                verdict_q = VERD_WAIT;
            end
            last_main = i;
            minor_cnt = 0;
            last_minor = -1;
        end
    endfunction

    function void note_sample(in_item_t item);
        int s;
        int len;
        int avg;
        int lim;
        int d;
        int h;
        int w;
        logic [15:0] cbits;
        logic [2:0] prev_v;
        out_item_t r;
        s = int'(item.sample);
        if (item.first) clear_trace();
        len = 1 << cfg.baseline_log2;
        if (len > RING_DEPTH) len = RING_DEPTH;
        avg = ring_sum / len;
        lim = int'(cfg.baseline_limit);
        if (s <= lim && s >= -lim)
        begin
            if (ring_ptr >= len) ring_ptr = 0;
            ring_sum -= int'(ring[ring_ptr]);
            ring[ring_ptr] = s[15:0];
            ring_sum += s;
            ring_ptr++;
            if (ring_ptr >= len) ring_ptr = 0;
        end
        cbits = 16'(s - avg);
        if (idx == 0)
            w = 0;
        else
        begin
            d = prev_corr - int'($signed(cbits));
            h = (d >= 0) ? d / 2 : -((1 - d) / 2);
            w = (h < 0) ? -h : h;
            if (w > 32767) w = 32767;
        end
        prev_corr = int'($signed(cbits));
        prev_v = verdict_q;
        if (idx < MAX_TRACE)
        begin
            if (verdict_q != VERD_TRIG) search(idx, w);
            idx++;
        end
        r.corrected_sample = cbits;
        r.wavelet_value    = w[14:0];
        r.verdict          = (verdict_q == VERD_WAIT && armed) ? VERD_ARMED : verdict_q;
        r.trigger_position = (verdict_q == VERD_TRIG) ? found_pos[16:0] : '0;
        r.trigger_now      = (verdict_q == VERD_TRIG && prev_v != VERD_TRIG);
        pending.push_back(r);
    endfunction

    function void check_result(out_item_t act);
        out_item_t exp;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, act);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (act.corrected_sample !== exp.corrected_sample)
            $display("%0t: corrected_sample expected %0d actual %0d", $time,
                     exp.corrected_sample, act.corrected_sample);
        if (act.wavelet_value !== exp.wavelet_value)
            $display("%0t: wavelet_value expected %0d actual %0d", $time,
                     exp.wavelet_value, act.wavelet_value);
        if (act.verdict !== exp.verdict)
            $display("%0t: verdict expected %0d actual %0d", $time,
                     exp.verdict, act.verdict);
        if (act.trigger_position !== exp.trigger_position)
            $display("%0t: trigger_position expected %0d actual %0d", $time,
                     exp.trigger_position, act.trigger_position);
        if (act.trigger_now !== exp.trigger_now)
            $display("%0t: trigger_now expected %0d actual %0d", $time,
                     exp.trigger_now, act.trigger_now);
        if (act !== exp) errors++;
    endfunction
endclass

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives traces of random and pulse-shaped samples through the trigger under
// several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import bwpt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        sample_valid;
    logic        sample_ready;
    in_item_t    sample_item;
    logic        result_valid;
    logic        result_ready;
    out_item_t   result_item;

    bwpt_scoreboard sb;
    int  cycles;
    bit  hold_off;

    baseline_wavelet_pulse_trigger u_dut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(3, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("baseline_wavelet_pulse_trigger verification failed");
            $finish;
        end
        if (rst_n && sample_valid && sample_ready) sb.note_sample(sample_item);
        if (rst_n && result_valid && result_ready) sb.check_result(result_item);
    end

    // receiver with random stalls and a long hold-off on request
    initial
    begin
        int n;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                result_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (n > 0)
            begin
                result_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                result_ready <= 1'b1;
        end
    end

    task automatic reg_write(logic [2:0] r, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(r, v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send(logic signed [15:0] s, logic f, bit gaps);
        int n;
        sample_item <= '{sample: s, first: f};
        sample_valid <= 1'b1;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
        @(negedge clk);
        n = gaps ? (($urandom_range(0, 2) == 0) ? gap_len() : 0) : 0;
        if (n > 0)
        begin
            sample_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic settings(int phase);
        logic [31:0] v [8];
        if (phase == 0)
            v = '{12'hfff, 12'hfff, 9'h1ff, 9'h1ff, 12'hfff, 10'h3ff, 3'd7, 16'hffff};
        else if (phase == 1)
            v = '{0, 0, 0, 0, 0, 0, 0, 0};
        else
            v = '{$urandom_range(5, 400), $urandom_range(0, 200), $urandom_range(0, 8),
                  $urandom_range(1, 20), $urandom, $urandom_range(0, 1023),
                  $urandom_range(0, 7), $urandom_range(0, 120)};
        for (int k = 0; k < 8; k++) reg_write(k[2:0], v[k]);
    endtask

    // a trace: baseline noise with a pulse of random amplitude and position
    task automatic pulse_trace(bit gaps);
        int len;
        int amp;
        int at;
        len = $urandom_range(20, 90);
        amp = $urandom_range(100, 3000);
        at = $urandom_range(2, 30);
        for (int k = 0; k < len; k++)
        begin
            int s;
            s = $urandom_range(0, 40) - 20;
            if (k >= at && k < at + 4) s += amp * ((k - at) % 2 ? -1 : 1);
            send(16'(s), k == 0, gaps);
        end
    endtask

    initial
    begin
        int sent;
        sb = new();
        sb.set_defaults();
        cycles = 0;
        hold_off = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_valid = 1'b0;
        sample_item = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // defaults, then field extremes and big swings
        send(16'sh7fff, 1'b0, 0);
        send(-16'sh8000, 1'b0, 0);
        send(16'sh7fff, 1'b0, 0);
        send(16'sd0, 1'b1, 0);
        send(16'sd500, 1'b0, 0);
        send(-16'sd500, 1'b0, 0);
        drain();
        settings(0);
        send(-16'sh8000, 1'b1, 0);
        send(16'sh7fff, 1'b0, 0);
        send(16'sd1023, 1'b0, 0);
        send(-16'sd1023, 1'b0, 0);
        drain();
        settings(1);
        for (int k = 0; k < 8; k++) send(16'(k * 37 - 100), k == 0, 0);
        drain();

        sent = 0;
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            settings(2);
            reg_write(REG_QUIET_AFT, $urandom_range(1, 6));
            reg_write(REG_EXP_POS, $urandom_range(0, 40));
            if (phase == 3) hold_off = 1;
            for (int t = 0; t < 2; t++) pulse_trace(1);
            for (int k = 0; k < 10; k++) send(16'($urandom), $urandom_range(0, 9) == 0, 1);
            if (phase == 5) drain();
        end
        drain();
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("baseline_wavelet_pulse_trigger verification clean");
        else
            $display("baseline_wavelet_pulse_trigger verification failed");
        $finish;
    end
endmodule
